// ===== hw/rtl/dfpm_pkg.sv =====
// Package for the DLE-framed packet matcher.
// Holds the framing symbols, the length counter width, the phase encoding and
// the result type. No dependencies.
package dfpm_pkg;

   // Width of the saturating length counter (legal range 4 to 32).
   localparam int LEN_BITS = 16;
   // Width of the reported packet length.
   localparam int OUT_LEN_BITS = 16;

   // Framing symbols.
   localparam logic [7:0] SYM_STX = 8'h02;
   localparam logic [7:0] SYM_ETX = 8'h03;
   localparam logic [7:0] SYM_ACK = 8'h06;
   localparam logic [7:0] SYM_DLE = 8'h10;

   // Largest value of the length counter.
   localparam logic [LEN_BITS-1:0] LEN_MAX = {LEN_BITS{1'b1}};
   // Largest reportable length.
   localparam logic [OUT_LEN_BITS-1:0] OUT_LEN_MAX = {OUT_LEN_BITS{1'b1}};

   // Frame recognition phases, one-hot.
   typedef enum logic [5:0] {
      PH_WAIT_DLE  = 6'b000001,  // Waiting for an opening DLE.
      PH_OPENED    = 6'b000010,  // Opening DLE seen.
      PH_FIRST     = 6'b000100,  // Expecting the first data byte.
      PH_DATA      = 6'b001000,  // Data, searching for a checksum.
      PH_CANDIDATE = 6'b010000,  // After a candidate checksum byte.
      PH_CAND_DLE  = 6'b100000   // After a DLE that follows a candidate.
   } phase_type;

   // One result transaction.
   typedef struct packed {
      logic                    matched;
      logic [OUT_LEN_BITS-1:0] packet_length;
   } result_type;

endpackage

// ===== hw/rtl/dfpm_req_if.sv =====
// Request channel interface of the DLE-framed packet matcher.
// Carries one received byte per transaction. No dependencies.
interface dfpm_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

// ===== hw/rtl/dfpm_rsp_if.sv =====
// Response channel interface of the DLE-framed packet matcher.
// Carries the match flag and packet length per transaction. No dependencies.
interface dfpm_rsp_if;
   logic        valid;
   logic        ready;
   logic        matched;
   logic [15:0] packet_length;

   modport source (output valid, output matched, output packet_length, input ready);
   modport sink (input valid, input matched, input packet_length, output ready);
endinterface

// ===== hw/rtl/dfpm_frame_fsm.sv =====
// Frame recognition state machine of the DLE-framed packet matcher.
// Updates phase, length count and running sum once per accepted byte and
// forms that byte's result. Depends on dfpm_pkg.
module dfpm_frame_fsm (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  byte_valid,
   input  logic [7:0]            rx_byte,
   output dfpm_pkg::result_type  result
);

   dfpm_pkg::phase_type              phase_ff, phase_in;
   logic [dfpm_pkg::LEN_BITS-1:0]    count_ff, count_in;
   logic [7:0]                       sum_ff, sum_in;
   logic [dfpm_pkg::LEN_BITS-1:0]    count_inc;
   logic [7:0]                       sum_add;
   logic                             hit;
   logic [31:0]                      count_wide;

   // Saturating increment of the length count and running sum update.
   assign count_inc = (count_ff == dfpm_pkg::LEN_MAX) ? count_ff : count_ff + 1'b1;
   assign sum_add   = sum_ff + rx_byte;

   // Next state for the byte on the input.
   always_comb begin
      phase_in = phase_ff;
      count_in = count_ff;
      sum_in   = sum_ff;
      hit      = 1'b0;
      case (phase_ff)
         dfpm_pkg::PH_WAIT_DLE: begin
            if (rx_byte == dfpm_pkg::SYM_DLE) begin
               count_in = dfpm_pkg::LEN_BITS'(1);
               phase_in = dfpm_pkg::PH_OPENED;
            end
         end
         dfpm_pkg::PH_OPENED: begin
            if (rx_byte == dfpm_pkg::SYM_STX) begin
               count_in = count_inc;
               phase_in = dfpm_pkg::PH_FIRST;
            end else if (rx_byte == dfpm_pkg::SYM_ACK) begin
               count_in = count_inc;
               phase_in = dfpm_pkg::PH_WAIT_DLE;
               hit      = 1'b1;
            end else begin
               phase_in = dfpm_pkg::PH_WAIT_DLE;
            end
         end
         dfpm_pkg::PH_FIRST: begin
            sum_in   = rx_byte;
            count_in = count_inc;
            phase_in = dfpm_pkg::PH_DATA;
         end
         dfpm_pkg::PH_DATA: begin
            if (sum_ff == rx_byte) begin
               phase_in = dfpm_pkg::PH_CANDIDATE;
            end
            sum_in   = sum_add;
            count_in = count_inc;
         end
         dfpm_pkg::PH_CANDIDATE: begin
            count_in = count_inc;
            if (rx_byte == dfpm_pkg::SYM_DLE) begin
               phase_in = dfpm_pkg::PH_CAND_DLE;
            end else begin
               if (sum_ff != rx_byte) begin
                  phase_in = dfpm_pkg::PH_DATA;
               end
               sum_in = sum_add;
            end
         end
         dfpm_pkg::PH_CAND_DLE: begin
            count_in = count_inc;
            if (rx_byte == dfpm_pkg::SYM_ETX) begin
               phase_in = dfpm_pkg::PH_WAIT_DLE;
               hit      = 1'b1;
            end else begin
               phase_in = (sum_ff == rx_byte) ? dfpm_pkg::PH_CANDIDATE : dfpm_pkg::PH_DATA;
               sum_in   = sum_add;
            end
         end
         default: begin
            phase_in = dfpm_pkg::PH_WAIT_DLE;
         end
      endcase
   end

   // The reported length is the updated count, clipped to the output width; it is zero when no frame matched.
   assign count_wide = 32'(count_in);
   always_comb begin
      result.matched = hit;
      if (!hit) begin
         result.packet_length = '0;
      end else if (count_wide > 32'(dfpm_pkg::OUT_LEN_MAX)) begin
         result.packet_length = dfpm_pkg::OUT_LEN_MAX;
      end else begin
         result.packet_length = count_wide[dfpm_pkg::OUT_LEN_BITS-1:0];
      end
   end

   // State registers advance only on an accepted byte.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= dfpm_pkg::PH_WAIT_DLE;
         count_ff <= '0;
         sum_ff   <= '0;
      end else if (byte_valid) begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         sum_ff   <= sum_in;
      end
   end

   // A completed frame always holds at least the DLE and one more byte.
   assert property (@(posedge clock) disable iff (reset)
      byte_valid && result.matched |-> result.packet_length >= 16'd2)
      else $error("Matched frame reported shorter than two bytes.");

   // An opening DLE restarts the count at one.
   assert property (@(posedge clock) disable iff (reset)
      byte_valid && phase_ff == dfpm_pkg::PH_WAIT_DLE && rx_byte == dfpm_pkg::SYM_DLE
      |=> count_ff == dfpm_pkg::LEN_BITS'(1) && phase_ff == dfpm_pkg::PH_OPENED)
      else $error("Opening DLE did not restart the frame.");

   // Without an accepted byte the frame state holds.
   assert property (@(posedge clock) disable iff (reset)
      !byte_valid |=> $stable(phase_ff) && $stable(count_ff) && $stable(sum_ff))
      else $error("Frame state changed without an accepted byte.");

endmodule

// ===== hw/rtl/dfpm_rsp_buffer.sv =====
// Two-entry response buffer (output register plus skid register) of the
// DLE-framed packet matcher. Depends on dfpm_pkg.
module dfpm_rsp_buffer (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  dfpm_pkg::result_type  in_data,
   output logic                  in_ready,
   output logic                  out_valid,
   output dfpm_pkg::result_type  out_data,
   input  logic                  out_ready
);

   logic                  out_valid_ff, out_valid_in;
   logic                  skid_valid_ff, skid_valid_in;
   dfpm_pkg::result_type  out_data_ff, out_data_in;
   dfpm_pkg::result_type  skid_data_ff, skid_data_in;
   logic                  out_free;

   // The output register is free when empty or being taken this cycle.
   assign out_free  = !out_valid_ff || out_ready;
   assign in_ready  = !skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

   // Move the skid entry forward first; new transactions fill whichever
   // register is free.
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (out_free) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = in_valid;
            out_data_in  = in_data;
         end
      end else if (in_valid) begin
         skid_valid_in = 1'b1;
         skid_data_in  = in_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   // The skid register only fills behind a held output register.
   assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("Skid entry present with empty output register.");

   // A stalled output with a new transaction parks it in the skid register.
   assert property (@(posedge clock) disable iff (reset)
      in_valid && in_ready && out_valid_ff && !out_ready |=> skid_valid_ff)
      else $error("Transaction lost while output stalled.");

   // A taken output with a skid entry moves that entry forward.
   assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff && out_ready |=> out_valid_ff && !skid_valid_ff
      && out_data_ff == $past(skid_data_ff))
      else $error("Skid entry not forwarded.");

endmodule

// ===== hw/rtl/dle_framed_packet_matcher_top.sv =====
// Top level of the DLE-framed packet matcher.
// Depends on dfpm_pkg, dfpm_req_if, dfpm_rsp_if, dfpm_frame_fsm and
// dfpm_rsp_buffer.
//
//   Channel   Direction  Payload                              Handshake
//   req_chan  in         rx_byte[7:0]                         valid/ready
//   rsp_chan  out        matched, packet_length[15:0]         valid/ready
//
// Each request transaction yields exactly one response transaction, held in the
// output register, or in the skid register while the output is stalled.
// A byte can be accepted in every cycle while req_chan.ready is high; the frame
// state updates in that same cycle and its result enters the output buffer.
// A two-entry output buffer decouples the sides: req_chan.ready drops only
// while both the output and skid registers hold untaken results.
// Reset is synchronous and active high; it returns the matcher to waiting for
// a DLE and empties the output buffer. No clearing pass is needed.
module dle_framed_packet_matcher_top (
   input  logic       clock,
   input  logic       reset,
   dfpm_req_if.sink   req_chan,
   dfpm_rsp_if.source rsp_chan
);

   logic                  req_accept;
   logic                  req_ready;
   dfpm_pkg::result_type  fsm_result;
   dfpm_pkg::result_type  rsp_data;

   assign req_chan.ready = req_ready;
   assign req_accept     = req_chan.valid && req_ready;

   // Frame recognition.
   dfpm_frame_fsm u_frame_fsm (
      .clock      (clock),
      .reset      (reset),
      .byte_valid (req_accept),
      .rx_byte    (req_chan.rx_byte),
      .result     (fsm_result)
   );

   // Response buffering.
   dfpm_rsp_buffer u_rsp_buffer (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_accept),
      .in_data   (fsm_result),
      .in_ready  (req_ready),
      .out_valid (rsp_chan.valid),
      .out_data  (rsp_data),
      .out_ready (rsp_chan.ready)
   );

   assign rsp_chan.matched       = rsp_data.matched;
   assign rsp_chan.packet_length = rsp_data.packet_length;

endmodule
